>>> rtl/tsar_pkg.sv
// Shared types, constants and helpers for the TCP SYN/ACK responder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tsar_pkg;

  localparam int unsigned HdrBytes   = 40;
  localparam int unsigned ReplyBytes = 48;
  localparam int unsigned JobDepth   = 2;

  typedef logic [5:0]  pos_t;
  typedef logic [19:0] sum_t;

  localparam pos_t        LastPos     = 6'(ReplyBytes - 1);
  localparam logic [7:0]  VerIhl      = 8'h45;
  localparam logic [7:0]  ProtoTcp    = 8'h06;
  localparam logic [7:0]  TcpFlagAck  = 8'h10;
  localparam logic [3:0]  ReplyOffset = 4'h7;
  localparam logic [7:0]  OptMssKind  = 8'h02;
  localparam logic [7:0]  OptMssLen   = 8'h04;
  localparam logic [7:0]  OptWsKind   = 8'h03;
  localparam logic [7:0]  OptWsLen    = 8'h03;

  // IP: total length word 0x0030. TCP: segment length 28 plus option kind/length words.
  localparam sum_t IpSumInit  = 20'h00030;
  localparam sum_t TcpSumInit = 20'h0001c + 20'h00204 + 20'h00303;

  typedef enum logic [1:0] {
    REG_SEQ    = 2'd0,
    REG_MSS    = 2'd1,
    REG_WSCALE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] mss;
    logic [3:0]  wscale;
  } cfg_t;

  typedef struct packed {
    logic       we;
    logic       bank;
    pos_t       addr;
    logic [7:0] data;
  } hdr_wr_t;

  typedef struct packed {
    logic        bank;
    sum_t        ip_sum;
    sum_t        tcp_sum;
    logic [31:0] rx_seq;
  } job_t;

  // Stored header position that feeds reply position k: addresses and ports swap.
  function automatic pos_t src_pos(pos_t k);
    pos_t p;
    p = k;
    if (k >= 6'd12 && k <= 6'd15) p = k + 6'd4;
    else if (k >= 6'd16 && k <= 6'd19) p = k - 6'd4;
    else if (k == 6'd20 || k == 6'd21) p = k + 6'd2;
    else if (k == 6'd22 || k == 6'd23) p = k - 6'd2;
    return p;
  endfunction

  // One end-around carry step of a ones' complement sum.
  function automatic sum_t fold(sum_t s);
    return {4'd0, s[15:0]} + {16'd0, s[19:16]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/tcp_syn_ack_responder_unit.sv
// Top level of the TCP SYN/ACK responder: configuration registers and the front / job queue /
// header memory / back chain. Depends on tsar_pkg and all tsar_* modules but tsar_checker.
//
//   channel   direction  handshake                    payload
//   packet    in         packet_valid_i/ready_o       packet_byte_i, packet_last_i
//   reply     out        reply_valid_o/ready_i        reply_byte_o, reply_last_o
//   cfg       in         cfg_valid_i/ready_o          cfg_index_i, cfg_data_i
//
// Packet bytes are taken one per cycle; the front stalls only while two replies
// are queued, since each queued reply holds one of the two header banks.
// Each reply runs the checksum finish states (ADD1, ADD2, FOLD1, FOLD2), then its bytes pass
// the one-byte output register; packets that outpace the replies pile up in the queue.
// Reset clears the control state; the header memory needs no clearing pass.
// Reply stalls back up through the output register and the memory read stage.
`default_nettype none

module tcp_syn_ack_responder_unit import tsar_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        packet_valid_i,
  output logic             packet_ready_o,
  input  wire logic [7:0]  packet_byte_i,
  input  wire logic        packet_last_i,
  output logic             reply_valid_o,
  input  wire logic        reply_ready_i,
  output logic [7:0]       reply_byte_o,
  output logic             reply_last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    job_full, job_push, job_valid, job_pop;
  job_t    job_in, job_head;
  hdr_wr_t hdr_wr;
  logic    rd_en, rd_bank;
  pos_t    rd_pos;
  logic [7:0] rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seq    <= 32'd42;
      cfg_q.mss    <= 16'd1460;
      cfg_q.wscale <= 4'd7;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SEQ:    cfg_q.seq    <= cfg_data_i;
        REG_MSS:    cfg_q.mss    <= cfg_data_i[15:0];
        REG_WSCALE: cfg_q.wscale <= cfg_data_i[3:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  tsar_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .packet_valid_i (packet_valid_i),
    .packet_ready_o (packet_ready_o),
    .packet_byte_i  (packet_byte_i),
    .packet_last_i  (packet_last_i),
    .job_full_i     (job_full),
    .job_push_o     (job_push),
    .job_o          (job_in),
    .hdr_wr_o       (hdr_wr)
  );

  tsar_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .head_o  (job_head)
  );

  tsar_hdr_ram u_hdr_ram (
    .clk_i     (clk_i),
    .wr_i      (hdr_wr),
    .rd_en_i   (rd_en),
    .rd_bank_i (rd_bank),
    .rd_pos_i  (rd_pos),
    .rd_data_o (rd_data)
  );

  tsar_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .rd_en_o       (rd_en),
    .rd_bank_o     (rd_bank),
    .rd_pos_o      (rd_pos),
    .rd_data_i     (rd_data),
    .reply_valid_o (reply_valid_o),
    .reply_ready_i (reply_ready_i),
    .reply_byte_o  (reply_byte_o),
    .reply_last_o  (reply_last_o)
  );

endmodule

`default_nettype wire

>>> rtl/tsar_hdr_ram.sv
// Two-bank header memory: the front fills one bank while the back reads the other.
// Depends on tsar_pkg.
`default_nettype none

module tsar_hdr_ram import tsar_pkg::*; (
  input  wire logic       clk_i,
  input  wire hdr_wr_t    wr_i,
  input  wire logic       rd_en_i,
  input  wire logic       rd_bank_i,
  input  wire pos_t       rd_pos_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [2][HdrBytes];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.bank][wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_bank_i][rd_pos_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/tsar_front.sv
// Front end: accepts packet bytes, stores the header, screens the packet and
// accumulates the partial checksums. Depends on tsar_pkg.
`default_nettype none

module tsar_front import tsar_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       packet_valid_i,
  output logic            packet_ready_o,
  input  wire logic [7:0] packet_byte_i,
  input  wire logic       packet_last_i,
  input  wire logic       job_full_i,
  output logic            job_push_o,
  output job_t            job_o,
  output hdr_wr_t         hdr_wr_o
);

  pos_t        cnt_q;
  logic        bank_q;
  logic        ver_ok_q, proto_ok_q, syn_q;
  sum_t        ip_sum_q, tcp_sum_q;
  logic [31:0] rx_seq_q;

  logic        accept, in_hdr, hdr_full;
  sum_t        posit, ip_term, tcp_term, ip_sum_d, tcp_sum_d;

  assign packet_ready_o = !job_full_i;
  assign accept         = packet_valid_i && packet_ready_o;
  assign in_hdr         = cnt_q < 6'(HdrBytes);
  assign hdr_full       = cnt_q >= 6'(HdrBytes - 1);

  always_comb begin
    posit = cnt_q[0] ? {12'd0, packet_byte_i} : {4'd0, packet_byte_i, 8'd0};

    ip_term = '0;
    if ((cnt_q <= 6'd9 && cnt_q != 6'd2 && cnt_q != 6'd3) ||
        (cnt_q >= 6'd12 && cnt_q <= 6'd19)) begin
      ip_term = posit;
    end

    // received ack (28..31) and both checksums drop out of the reply sum
    tcp_term = '0;
    priority if (cnt_q == 6'd9) begin
      tcp_term = {12'd0, packet_byte_i};
    end else if ((cnt_q >= 6'd12 && cnt_q <= 6'd23) || cnt_q == 6'd34 ||
                 cnt_q == 6'd35 || cnt_q == 6'd38 || cnt_q == 6'd39) begin
      tcp_term = posit;
    end else if (cnt_q == 6'd32) begin
      tcp_term = {4'd0, ReplyOffset, packet_byte_i[3:0], 8'd0};
    end else if (cnt_q == 6'd33) begin
      tcp_term = {12'd0, packet_byte_i | TcpFlagAck};
    end else begin
      tcp_term = '0;
    end

    ip_sum_d  = ip_sum_q + ip_term;
    tcp_sum_d = tcp_sum_q + tcp_term;
  end

  assign job_push_o = accept && packet_last_i && hdr_full && ver_ok_q && proto_ok_q && syn_q;
  assign job_o      = '{bank: bank_q, ip_sum: ip_sum_d, tcp_sum: tcp_sum_d, rx_seq: rx_seq_q};
  assign hdr_wr_o   = '{we: accept && in_hdr, bank: bank_q, addr: cnt_q, data: packet_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      bank_q     <= 1'b0;
      ver_ok_q   <= 1'b0;
      proto_ok_q <= 1'b0;
      syn_q      <= 1'b0;
      ip_sum_q   <= IpSumInit;
      tcp_sum_q  <= TcpSumInit;
    end else if (accept) begin
      if (packet_last_i) begin
        cnt_q     <= '0;
        ip_sum_q  <= IpSumInit;
        tcp_sum_q <= TcpSumInit;
      end else begin
        ip_sum_q  <= ip_sum_d;
        tcp_sum_q <= tcp_sum_d;
        if (in_hdr) begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      if (cnt_q == 6'd0) ver_ok_q <= packet_byte_i == VerIhl;
      if (cnt_q == 6'd9) proto_ok_q <= packet_byte_i == ProtoTcp;
      if (cnt_q == 6'd33) syn_q <= packet_byte_i[1];
      if (job_push_o) begin
        bank_q <= !bank_q;
      end
    end
  end

  // shift in the received sequence number
  always_ff @(posedge clk_i) begin
    if (accept && cnt_q >= 6'd24 && cnt_q <= 6'd27) begin
      rx_seq_q <= {rx_seq_q[23:0], packet_byte_i};
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsar_job_fifo.sv
// Two-entry job queue between front and back; one entry per header bank.
// Depends on tsar_pkg.
`default_nettype none

module tsar_job_fifo import tsar_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      head_o
);

  job_t       slot_q [JobDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'(JobDepth);
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsar_back.sv
// Back end: finishes the checksums of a queued job and streams the 48-byte
// reply through a registered header read and an output register. Depends on tsar_pkg.
`default_nettype none

module tsar_back import tsar_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       job_valid_i,
  input  wire job_t       job_i,
  output logic            job_pop_o,
  output logic            rd_en_o,
  output logic            rd_bank_o,
  output pos_t            rd_pos_o,
  input  wire logic [7:0] rd_data_i,
  output logic            reply_valid_o,
  input  wire logic       reply_ready_i,
  output logic [7:0]      reply_byte_o,
  output logic            reply_last_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ADD1  = 6'b000010,
    ST_ADD2  = 6'b000100,
    ST_FOLD1 = 6'b001000,
    ST_FOLD2 = 6'b010000,
    ST_SEND  = 6'b100000
  } back_state_e;

  back_state_e state_q;
  pos_t        k_q, s1_k_q;
  logic        s1_valid_q, out_valid_q;
  logic        bank_q;
  sum_t        ip_sum_q, tcp_sum_q;
  logic [31:0] seq1_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        adv, issue;
  logic [15:0] ip_ck, tcp_ck;
  logic [7:0]  byte_d;

  assign adv       = s1_valid_q && (!out_valid_q || reply_ready_i);
  assign issue     = (state_q == ST_SEND) && (!s1_valid_q || adv);
  assign job_pop_o = issue && (k_q == LastPos);
  assign rd_en_o   = issue && (k_q < 6'(HdrBytes));
  assign rd_bank_o = bank_q;
  assign rd_pos_o  = src_pos(k_q);
  assign ip_ck     = ~ip_sum_q[15:0];
  assign tcp_ck    = ~tcp_sum_q[15:0];

  always_comb begin
    unique case (s1_k_q)
      6'd2:    byte_d = 8'd0;
      6'd3:    byte_d = 8'(ReplyBytes);
      6'd10:   byte_d = ip_ck[15:8];
      6'd11:   byte_d = ip_ck[7:0];
      6'd24:   byte_d = cfg_i.seq[31:24];
      6'd25:   byte_d = cfg_i.seq[23:16];
      6'd26:   byte_d = cfg_i.seq[15:8];
      6'd27:   byte_d = cfg_i.seq[7:0];
      6'd28:   byte_d = seq1_q[31:24];
      6'd29:   byte_d = seq1_q[23:16];
      6'd30:   byte_d = seq1_q[15:8];
      6'd31:   byte_d = seq1_q[7:0];
      6'd32:   byte_d = {ReplyOffset, rd_data_i[3:0]};
      6'd33:   byte_d = rd_data_i | TcpFlagAck;
      6'd36:   byte_d = tcp_ck[15:8];
      6'd37:   byte_d = tcp_ck[7:0];
      6'd40:   byte_d = OptMssKind;
      6'd41:   byte_d = OptMssLen;
      6'd42:   byte_d = cfg_i.mss[15:8];
      6'd43:   byte_d = cfg_i.mss[7:0];
      6'd44:   byte_d = OptWsKind;
      6'd45:   byte_d = OptWsLen;
      6'd46:   byte_d = {4'd0, cfg_i.wscale};
      6'd47:   byte_d = 8'd0;
      default: byte_d = (s1_k_q < 6'(HdrBytes)) ? rd_data_i : 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE:  if (job_valid_i) state_q <= ST_ADD1;
        ST_ADD1:  state_q <= ST_ADD2;
        ST_ADD2:  state_q <= ST_FOLD1;
        ST_FOLD1: state_q <= ST_FOLD2;
        ST_FOLD2: begin
          k_q     <= '0;
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (issue) begin
            k_q <= k_q + 6'd1;
            if (k_q == LastPos) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (issue) s1_valid_q <= 1'b1;
      else if (adv) s1_valid_q <= 1'b0;

      if (adv) out_valid_q <= 1'b1;
      else if (reply_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        bank_q    <= job_i.bank;
        ip_sum_q  <= job_i.ip_sum;
        tcp_sum_q <= job_i.tcp_sum;
        seq1_q    <= job_i.rx_seq + 32'd1;
      end
      ST_ADD1: begin
        ip_sum_q  <= fold(ip_sum_q);
        tcp_sum_q <= tcp_sum_q + {4'd0, cfg_i.seq[31:16]} + {4'd0, cfg_i.seq[15:0]} +
                     {4'd0, cfg_i.mss} + {8'd0, cfg_i.wscale, 8'd0};
      end
      ST_ADD2: begin
        ip_sum_q  <= fold(ip_sum_q);
        tcp_sum_q <= tcp_sum_q + {4'd0, seq1_q[31:16]} + {4'd0, seq1_q[15:0]};
      end
      ST_FOLD1, ST_FOLD2: tcp_sum_q <= fold(tcp_sum_q);
      ST_SEND: ;
      default: ;
    endcase
    if (issue) s1_k_q <= k_q;
    if (adv) begin
      out_byte_q <= byte_d;
      out_last_q <= s1_k_q == LastPos;
    end
  end

  assign reply_valid_o = out_valid_q;
  assign reply_byte_o  = out_byte_q;
  assign reply_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/tsar_checker.sv
// Port-level checks for the TCP SYN/ACK responder and the bind that attaches them.
// Depends on tsar_pkg and tcp_syn_ack_responder_unit.
`default_nettype none

module tsar_checker import tsar_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       reply_valid_o,
  input wire logic       reply_ready_i,
  input wire logic [7:0] reply_byte_o,
  input wire logic       reply_last_o
);

  logic beat_acc;
  pos_t beat_q;

  assign beat_acc = reply_valid_o && reply_ready_i;

  // position of the next reply beat within its packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (beat_acc) begin
      beat_q <= (beat_q == LastPos) ? 6'd0 : beat_q + 6'd1;
    end
  end

  a_reply_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && !reply_ready_i |=>
      reply_valid_o && $stable(reply_byte_o) && $stable(reply_last_o))
    else $error("reply beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !reply_valid_o)
    else $error("reply valid during reset");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_acc |-> (reply_last_o == (beat_q == LastPos)))
    else $error("reply last marker not on beat 48");

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_acc && (beat_q == 6'd0) |-> (reply_byte_o == VerIhl))
    else $error("reply does not open with version 4, IHL 5");

  a_proto_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_acc && (beat_q == 6'd9) |-> (reply_byte_o == ProtoTcp))
    else $error("reply protocol byte is not TCP");

endmodule

bind tcp_syn_ack_responder_unit tsar_checker u_tsar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .reply_valid_o (reply_valid_o),
  .reply_ready_i (reply_ready_i),
  .reply_byte_o  (reply_byte_o),
  .reply_last_o  (reply_last_o)
);

`default_nettype wire
